>>> sv/sdw_pkg.sv
package sdw_pkg;

    // Operation codes carried by an input item.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SHOW = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS = 1'b1;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [7:0] BRIGHTNESS_RESET = 8'd143;
    localparam logic [15:0] TICKS_RESET = 16'd5;

    // Fixed command bytes and the decimal point bit.
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hc0;
    localparam logic [7:0] DP_MASK = 8'h80;

    // Binary to BCD shift register: five BCD digits above the 16-bit binary part.
    localparam int BIN_W = 16;
    localparam int BCD_W = 20;
    localparam int CONV_W = BIN_W + BCD_W;

    // Index of the final segment of the wire sequence.
    localparam logic [3:0] SEG_LAST_IDX = 4'd11;

    // Kinds of segment in the wire sequence.
    typedef enum logic [1:0] {
        SEG_START,
        SEG_BYTE,
        SEG_STOP
    } seg_kind_t;

    // One item as it travels through the pipeline.
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [CONV_W-1:0] conv;
        logic [7:0]        extra;
    } item_t;

    // Live configuration values.
    typedef struct packed {
        logic [7:0]  brightness;
        logic [15:0] ticks;
    } cfg_t;

    // Eight shift-and-adjust steps of the double dabble conversion.
    function automatic logic [CONV_W-1:0] dd_half(input logic [CONV_W-1:0] x);
        logic [CONV_W-1:0] r;
        r = x;
        for (int i = 0; i < 8; i++) begin
            for (int d = 0; d < 5; d++) begin
                if (r[BIN_W + 4*d +: 4] >= 4'd5)
                begin
                    r[BIN_W + 4*d +: 4] = r[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            r = {r[CONV_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Seven-segment pattern of one decimal digit.
    function automatic logic [7:0] digit_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0: p = 8'h3f;
            4'd1: p = 8'h06;
            4'd2: p = 8'h5b;
            4'd3: p = 8'h4f;
            4'd4: p = 8'h66;
            4'd5: p = 8'h6d;
            4'd6: p = 8'h7d;
            4'd7: p = 8'h07;
            4'd8: p = 8'h7f;
            4'd9: p = 8'h6f;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // Plan of the wire sequence, one entry per segment.
    function automatic seg_kind_t seg_kind(input logic [3:0] s);
        seg_kind_t k;
        case (s)
            4'd0, 4'd2, 4'd5: k = SEG_START;
            4'd1, 4'd3, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: k = SEG_BYTE;
            default: k = SEG_STOP;
        endcase
        return k;
    endfunction

    // Which byte of the sequence a byte segment sends.
    function automatic logic [2:0] byte_index(input logic [3:0] s);
        logic [2:0] k;
        case (s)
            4'd1: k = 3'd0;
            4'd3: k = 3'd1;
            4'd6: k = 3'd2;
            4'd7: k = 3'd3;
            4'd8: k = 3'd4;
            4'd9: k = 3'd5;
            4'd10: k = 3'd6;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

>>> sv/seven_segment_serial_display_writer.sv
// Path of an item: input register, both conversion halves, result register.
// Throughput: one item per cycle; the input stalls only while a result waits
// at a stalled output, since all stages advance together.
// Reset: asynchronous and active low; the block goes idle with both lines
// high, the registers at their default values and no result pending.
module seven_segment_serial_display_writer
    import sdw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   operation,
    input  logic [15:0]            shown_value,
    input  logic [7:0]             extra_segments,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   clock_line,
    output logic                   data_line,
    output logic                   busy_res,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        adv;
    item_t       in_reg, in_next;
    item_t       mid_item, conv_item;
    cfg_t        cfg;
    logic [7:0]  bright_reg, bright_next;
    logic [15:0] ticks_reg, ticks_next;

    // The pipeline moves whenever the result register is free or being taken.
    assign adv = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Input register.
    always_comb
    begin
        in_next = in_reg;
        if (adv)
        begin
            in_next.valid = in_valid;
            in_next.op = operation;
            in_next.conv = {{BCD_W{1'b0}}, shown_value};
            in_next.extra = extra_segments;
        end
    end

    // Configuration registers.
    always_comb
    begin
        bright_next = bright_reg;
        ticks_next = ticks_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS: bright_next = cfg_data[7:0];
                CFG_TICKS:      ticks_next = cfg_data[15:0];
                default:        bright_next = bright_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
            bright_reg <= BRIGHTNESS_RESET;
            ticks_reg <= TICKS_RESET;
        end
        else
        begin
            in_reg <= in_next;
            bright_reg <= bright_next;
            ticks_reg <= ticks_next;
        end
    end

    assign cfg.brightness = bright_reg;
    assign cfg.ticks = ticks_reg;

    // Decimal conversion in two registered halves.
    sdw_bcd_stage u_bcd_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item_in  (in_reg),
        .item_out (mid_item)
    );

    sdw_bcd_stage u_bcd_lo (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .item_in  (mid_item),
        .item_out (conv_item)
    );

    // Wire sequencer and result register.
    sdw_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item       (conv_item),
        .cfg        (cfg),
        .res_valid  (out_valid),
        .clock_line (clock_line),
        .data_line  (data_line),
        .busy_res   (busy_res)
    );

endmodule

>>> sv/sdw_bcd_stage.sv
module sdw_bcd_stage
    import sdw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  item_t item_in,
    output item_t item_out
);

    item_t item_reg;
    item_t item_next;

    // Half of the decimal conversion; the other fields ride along.
    always_comb
    begin
        item_next = item_reg;
        if (adv)
        begin
            item_next = item_in;
            item_next.conv = dd_half(item_in.conv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

>>> sv/sdw_sequencer.sv
module sdw_sequencer
    import sdw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  res_valid,
    output logic  clock_line,
    output logic  data_line,
    output logic  busy_res
);

    logic        busy_reg, busy_next;
    logic [3:0]  seg_reg, seg_next;
    logic [4:0]  off_reg, off_next;
    logic [3:0]  bit_reg, bit_next;
    logic [1:0]  sub_reg, sub_next;
    logic [15:0] timer_reg, timer_next;
    logic        clk_reg, clk_next;
    logic        dat_reg, dat_next;
    logic        valid_reg, valid_next;
    logic [7:0]  bytes_reg [4];
    logic [7:0]  bytes_next [4];

    seg_kind_t   kind, nkind;
    logic [4:0]  last_off;
    logic [3:0]  nseg;
    logic [4:0]  noff;
    logic [3:0]  nbit;
    logic [1:0]  nsub;
    logic [2:0]  k;
    logic [2:0]  k_mem;
    logic [7:0]  bval;
    logic        nclk, ndat;
    logic [16:0] timer_inc;
    logic [15:0] limit;
    logic        tick_done;
    logic        last_phase;

    // Position of the next line phase within the sequence.
    always_comb
    begin
        kind = seg_kind(seg_reg);
        case (kind)
            SEG_START: last_off = 5'd2;
            SEG_STOP:  last_off = 5'd3;
            default:   last_off = 5'd25;
        endcase
        if (off_reg == last_off)
        begin
            nseg = seg_reg + 4'd1;
            noff = 5'd0;
            nbit = 4'd0;
            nsub = 2'd0;
        end
        else
        begin
            nseg = seg_reg;
            noff = off_reg + 5'd1;
            if (sub_reg == 2'd2)
            begin
                nsub = 2'd0;
                nbit = bit_reg + 4'd1;
            end
            else
            begin
                nsub = sub_reg + 2'd1;
                nbit = bit_reg;
            end
        end
    end

    // Byte being sent in the next phase and the line levels it calls for.
    always_comb
    begin
        nkind = seg_kind(nseg);
        k = byte_index(nseg);
        k_mem = k - 3'd3;
        case (k)
            3'd0: bval = cfg.brightness;
            3'd1: bval = CMD_DATA;
            3'd2: bval = CMD_ADDR;
            default: bval = bytes_reg[k_mem[1:0]];
        endcase
        nclk = clk_reg;
        ndat = dat_reg;
        case (nkind)
            SEG_START:
            begin
                nclk = (noff < 5'd2);
                ndat = (noff == 5'd0);
            end
            SEG_STOP:
            begin
                nclk = (noff >= 5'd2);
                if (noff == 5'd3)
                begin
                    ndat = 1'b1;
                end
                else if (noff != 5'd0)
                begin
                    ndat = 1'b0;
                end
            end
            default:
            begin
                if (nbit == 4'd8)
                begin
                    nclk = (nsub == 2'd1);
                end
                else
                begin
                    nclk = (nsub == 2'd2);
                    if (nsub != 2'd0)
                    begin
                        ndat = bval[nbit[2:0]];
                    end
                end
            end
        endcase
    end

    // Phase timing and the update made by each item.
    always_comb
    begin
        limit = (cfg.ticks == 16'd0) ? 16'd1 : cfg.ticks;
        timer_inc = {1'b0, timer_reg} + 17'd1;
        tick_done = (timer_inc >= {1'b0, limit});
        last_phase = (seg_reg == SEG_LAST_IDX) && (off_reg == 5'd3);

        busy_next = busy_reg;
        seg_next = seg_reg;
        off_next = off_reg;
        bit_next = bit_reg;
        sub_next = sub_reg;
        timer_next = timer_reg;
        clk_next = clk_reg;
        dat_next = dat_reg;
        bytes_next = bytes_reg;
        valid_next = adv ? item.valid : valid_reg;

        if (adv && item.valid)
        begin
            if (item.op == OP_SHOW)
            begin
                if (!busy_reg)
                begin
                    bytes_next[0] = digit_pattern(item.conv[BIN_W+8 +: 4]);
                    bytes_next[1] = digit_pattern(item.conv[BIN_W+4 +: 4]) | DP_MASK;
                    bytes_next[2] = digit_pattern(item.conv[BIN_W +: 4]);
                    bytes_next[3] = item.extra;
                    busy_next = 1'b1;
                    seg_next = 4'd0;
                    off_next = 5'd0;
                    bit_next = 4'd0;
                    sub_next = 2'd0;
                    timer_next = 16'd0;
                    clk_next = 1'b1;
                    dat_next = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (tick_done)
                begin
                    timer_next = 16'd0;
                    if (last_phase)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        seg_next = nseg;
                        off_next = noff;
                        bit_next = nbit;
                        sub_next = nsub;
                        clk_next = nclk;
                        dat_next = ndat;
                    end
                end
                else
                begin
                    timer_next = timer_inc[15:0];
                end
            end
        end
    end

    // Control state and line levels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seg_reg <= 4'd0;
            off_reg <= 5'd0;
            bit_reg <= 4'd0;
            sub_reg <= 2'd0;
            timer_reg <= 16'd0;
            clk_reg <= 1'b1;
            dat_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            seg_reg <= seg_next;
            off_reg <= off_next;
            bit_reg <= bit_next;
            sub_reg <= sub_next;
            timer_reg <= timer_next;
            clk_reg <= clk_next;
            dat_reg <= dat_next;
            valid_reg <= valid_next;
        end
    end

    // Latched segment bytes; they are only read once a request has written them.
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign res_valid = valid_reg;
    assign clock_line = clk_reg;
    assign data_line = dat_reg;
    assign busy_res = busy_reg;

endmodule

>>> sv/sdw_checker.sv
module sdw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        operation,
    input logic [15:0] shown_value,
    input logic [7:0]  extra_segments,
    input logic        out_valid,
    input logic        out_stall,
    input logic        clock_line,
    input logic        data_line,
    input logic        busy_res
);

    logic out_xfer;
    logic have_prev_reg;
    logic prev_clk_reg;
    logic prev_dat_reg;

    assign out_xfer = out_valid && !out_stall;

    // Line levels of the last result transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_clk_reg <= 1'b1;
            prev_dat_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            have_prev_reg <= 1'b1;
            prev_clk_reg <= clock_line;
            prev_dat_reg <= data_line;
        end
    end

    // A stalled input item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(operation)
            && $stable(shown_value) && $stable(extra_segments))
        else $error("stalled input item changed");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(clock_line)
            && $stable(data_line) && $stable(busy_res))
        else $error("stalled result changed");

    // The input is held back only by a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // An idle display leaves both wires released high.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> clock_line && data_line)
        else $error("lines not high while idle");

    // Successive results never move both wires at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && have_prev_reg
            |-> !((clock_line != prev_clk_reg) && (data_line != prev_dat_reg)))
        else $error("clock and data changed in the same phase");

endmodule

bind seven_segment_serial_display_writer sdw_checker u_sdw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .shown_value    (shown_value),
    .extra_segments (extra_segments),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .clock_line     (clock_line),
    .data_line      (data_line),
    .busy_res       (busy_res)
);
